FILE: rtl/cpf_pkg.sv
`default_nettype none

package cpf_pkg;

    // Framing limits
    localparam int MAX_FRAMES  = 7;
    localparam int FRAME_BYTES = 29;
    localparam int HDR_LEN     = 13;

    // Header constants
    localparam logic [7:0]  MAGIC_HI = 8'hA5;
    localparam logic [7:0]  MAGIC_LO = 8'h5A;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  CFG_RESET = 8'h01;

    // Configuration register indexes
    localparam logic [1:0] CFG_PACKET_TYPE    = 2'd0;
    localparam logic [1:0] CFG_FORMAT_VERSION = 2'd1;

    // Input kinds
    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Command opcodes passed from front to back
    localparam logic [1:0] OP_HDR       = 2'd0;
    localparam logic [1:0] OP_DATA      = 2'd1;
    localparam logic [1:0] OP_DATA_LAST = 2'd2;
    localparam logic [1:0] OP_REJ       = 2'd3;

    // Command queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] pkt_num;
        logic [31:0] timestamp;
        logic [7:0]  value;      // frame count on header, payload byte on data
    } cmd_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cpf_front.sv
`default_nettype none

module cpf_front
    import cpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_kind,
    input  wire logic [31:0] in_timestamp,
    input  wire logic [7:0]  in_frame_count,
    input  wire logic [7:0]  in_data_byte,
    input  wire logic        q_full,
    output logic             in_ready,
    output logic             push,
    output cmd_t             push_cmd
);

    logic        in_packet_reg, in_packet_next;
    logic [7:0]  left_reg, left_next;
    logic [31:0] pkt_reg, pkt_next;
    logic        take;
    logic        fc_bad;
    logic [15:0] prod;
    logic [7:0]  left_dec;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign fc_bad   = (in_frame_count == 8'd0) || (in_frame_count > 8'(MAX_FRAMES));
    assign prod     = 16'(in_frame_count) * 16'(FRAME_BYTES);
    assign left_dec = left_reg - 8'd1;

    // Classify the transaction and track packet progress
    always_comb
    begin
        in_packet_next     = in_packet_reg;
        left_next          = left_reg;
        pkt_next           = pkt_reg;
        push               = 1'b0;
        push_cmd.op        = OP_REJ;
        push_cmd.pkt_num   = pkt_reg;
        push_cmd.timestamp = in_timestamp;
        push_cmd.value     = in_data_byte;
        if (take)
        begin
            if (in_kind == KIND_START)
            begin
                push = 1'b1;
                if (fc_bad)
                begin
                    push_cmd.op    = OP_REJ;
                    in_packet_next = 1'b0;
                    left_next      = 8'd0;
                end
                else
                begin
                    push_cmd.op    = OP_HDR;
                    push_cmd.value = in_frame_count;
                    pkt_next       = pkt_reg + 32'd1;
                    left_next      = prod[7:0];
                    in_packet_next = 1'b1;
                end
            end
            else if (in_packet_reg)
            begin
                push      = 1'b1;
                left_next = left_dec;
                if (left_dec == 8'd0)
                begin
                    push_cmd.op    = OP_DATA_LAST;
                    in_packet_next = 1'b0;
                end
                else
                begin
                    push_cmd.op = OP_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            left_reg      <= 8'd0;
            pkt_reg       <= 32'd0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            left_reg      <= left_next;
            pkt_reg       <= pkt_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cpf_fifo.sv
`default_nettype none

module cpf_fifo
    import cpf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output logic      full,
    output logic      empty
);

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cpf_back.sv
`default_nettype none

module cpf_back
    import cpf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    input  wire cmd_t       head,
    input  wire logic       q_empty,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_rej
);

    logic [7:0]  ptype_reg, ver_reg;
    logic        busy_reg, busy_next;
    cmd_t        cur_reg, cur_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        rej_reg, rej_next;

    logic        adv, have;
    cmd_t        sel;
    logic [3:0]  sidx, lidx;
    logic [7:0]  ob, hb;
    logic [15:0] crc_base;
    logic        upd;

    assign adv  = !valid_reg || out_ready;
    assign have = busy_reg || !q_empty;
    assign sel  = busy_reg ? cur_reg : head;
    assign sidx = busy_reg ? idx_reg : 4'd0;
    assign pop  = adv && !busy_reg && !q_empty;

    // Header byte by offset
    always_comb
    begin
        case (sidx)
            4'd0:    hb = MAGIC_HI;
            4'd1:    hb = MAGIC_LO;
            4'd2:    hb = ptype_reg;
            4'd3:    hb = ver_reg;
            4'd4:    hb = sel.pkt_num[31:24];
            4'd5:    hb = sel.pkt_num[23:16];
            4'd6:    hb = sel.pkt_num[15:8];
            4'd7:    hb = sel.pkt_num[7:0];
            4'd8:    hb = sel.timestamp[31:24];
            4'd9:    hb = sel.timestamp[23:16];
            4'd10:   hb = sel.timestamp[15:8];
            4'd11:   hb = sel.timestamp[7:0];
            default: hb = sel.value;
        endcase
    end

    // Byte, CRC handling and length for the selected command
    always_comb
    begin
        ob       = 8'd0;
        upd      = 1'b0;
        lidx     = 4'd0;
        crc_base = crc_reg;
        case (sel.op)
            OP_HDR:
            begin
                ob   = hb;
                upd  = 1'b1;
                lidx = 4'(HDR_LEN - 1);
                if (sidx == 4'd0)
                    crc_base = CRC_INIT;
            end
            OP_DATA:
            begin
                ob  = sel.value;
                upd = 1'b1;
            end
            OP_DATA_LAST:
            begin
                lidx = 4'd2;
                if (sidx == 4'd0)
                begin
                    ob  = sel.value;
                    upd = 1'b1;
                end
                else if (sidx == 4'd1)
                    ob = crc_reg[15:8];
                else
                    ob = crc_reg[7:0];
            end
            default:
            begin
                ob = 8'd0;
            end
        endcase
    end

    // Output register advance
    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        rej_next   = rej_reg;
        busy_next  = busy_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        if (adv)
        begin
            valid_next = have;
            if (have)
            begin
                byte_next = ob;
                rej_next  = (sel.op == OP_REJ);
                last_next = (sel.op == OP_REJ) || ((sel.op == OP_DATA_LAST) && (sidx == 4'd2));
                if (upd)
                    crc_next = crc16_byte(crc_base, ob);
                if (sidx == lidx)
                    busy_next = 1'b0;
                else
                begin
                    busy_next = 1'b1;
                    cur_next  = sel;
                    idx_next  = sidx + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptype_reg <= CFG_RESET;
            ver_reg   <= CFG_RESET;
            busy_reg  <= 1'b0;
            idx_reg   <= 4'd0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_PACKET_TYPE))
                ptype_reg <= cfg_wdata;
            if (cfg_we && (cfg_index == CFG_FORMAT_VERSION))
                ver_reg <= cfg_wdata;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        rej_reg  <= rej_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_rej   = rej_reg;

endmodule

`default_nettype wire

FILE: rtl/crc_packet_framer.sv
// Packet framer with CRC-16/CCITT-FALSE. A start transaction (tuser 0) with a frame
// count of 1..MAX_FRAMES emits a 13-byte header (A5 5A, type, version, packet number,
// timestamp, frame count, multi-byte fields MSB first) and opens a packet of
// frame_count*FRAME_BYTES payload bytes; an invalid count emits one byte 0 with tlast
// and tuser set. Payload transactions (tuser 1) pass through one per cycle while the
// queue has room; the last one is followed by CRC high and low, low marked tlast. A
// start abandons an open packet; payload outside a packet is dropped. Rate: one output
// byte per cycle from a single output register while m_tready is high; a payload byte
// yields one byte, the last three, a start 13; a 4-entry command queue between the
// input classifier and the byte generator absorbs these bursts; input waits while full.
`default_nettype none

module crc_packet_framer
    import cpf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // timestamp[31:0], frame_count[39:32], data_byte[47:40]
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast,   // last
    output logic             m_tuser    // rejected
);

    logic push, pop, q_full, q_empty;
    cmd_t push_cmd, head;

    cpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_kind        (s_tuser),
        .in_timestamp   (s_tdata[31:0]),
        .in_frame_count (s_tdata[39:32]),
        .in_data_byte   (s_tdata[47:40]),
        .q_full         (q_full),
        .in_ready       (s_tready),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    cpf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    cpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_rej   (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/sv/crc_packet_framer_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels and the config port, predicts the framed
// byte stream and compares every output transaction against it.
module crc_packet_framer_checker
    import cpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // timestamp[31:0], frame_count[39:32], data_byte[47:40]
    input  logic        s_tuser,    // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // out_byte[7:0]
    input  logic        m_tlast,
    input  logic        m_tuser,    // rejected
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rejected;
    } framed_byte_t;

    localparam int MAX_PRINTS = 100;

    framed_byte_t framed_bytes_due[$];

    // Shadow of the framer state and header fields
    logic [31:0] pkt_counter;
    logic [15:0] crc_acc;
    logic [7:0]  bytes_left;
    logic        open_packet;
    logic [7:0]  type_field;
    logic [7:0]  version_field;

    int fail_count = 0;
    int pending_bytes = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending_bytes;

    // Serial CRC-16 update, one data bit per step, MSB first
    function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last, input logic rejected);
        framed_byte_t fb;
        fb.data     = data;
        fb.last     = last;
        fb.rejected = rejected;
        framed_bytes_due.push_back(fb);
    endtask

    // Expected output bytes caused by one accepted input transaction
    task automatic frame_transaction(input logic kind, input logic [31:0] ts,
                                     input logic [7:0] fc, input logic [7:0] db);
        logic [7:0]  hdr [HDR_LEN];
        logic [15:0] crc;
        if (kind == KIND_START)
        begin
            // any start drops an open packet
            open_packet = 1'b0;
            crc_acc     = CRC_INIT;
            bytes_left  = 8'd0;
            if (fc == 8'd0 || fc > MAX_FRAMES)
            begin
                push_byte(8'h00, 1'b1, 1'b1);
                return;
            end
            hdr = '{MAGIC_HI, MAGIC_LO, type_field, version_field,
                    pkt_counter[31:24], pkt_counter[23:16], pkt_counter[15:8], pkt_counter[7:0],
                    ts[31:24], ts[23:16], ts[15:8], ts[7:0], fc};
            pkt_counter = pkt_counter + 32'd1;
            crc = CRC_INIT;
            foreach (hdr[i])
            begin
                crc = crc16_shift(crc, hdr[i]);
                push_byte(hdr[i], 1'b0, 1'b0);
            end
            crc_acc     = crc;
            bytes_left  = 8'(fc * FRAME_BYTES);
            open_packet = 1'b1;
        end
        else if (open_packet)
        begin
            crc_acc = crc16_shift(crc_acc, db);
            push_byte(db, 1'b0, 1'b0);
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
            begin
                // CRC trailer, high byte first
                push_byte(crc_acc[15:8], 1'b0, 1'b0);
                push_byte(crc_acc[7:0], 1'b1, 1'b0);
                open_packet = 1'b0;
                crc_acc     = CRC_INIT;
            end
        end
    endtask

    task automatic compare_output();
        framed_byte_t want;
        if (framed_bytes_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %02h last %0b rejected %0b",
                                      m_tdata, m_tlast, m_tuser));
            return;
        end
        want = framed_bytes_due.pop_front();
        if (m_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                      m_tlast, want.last, want.data));
        if (m_tuser !== want.rejected)
            report_mismatch($sformatf("rejected %0b, want %0b (byte %02h)",
                                      m_tuser, want.rejected, want.data));
    endtask

    // Sample both channels and the config port at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_counter   = 32'd0;
            crc_acc       = CRC_INIT;
            bytes_left    = 8'd0;
            open_packet   = 1'b0;
            type_field    = CFG_RESET;
            version_field = CFG_RESET;
            framed_bytes_due.delete();
            pending_bytes <= 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    CFG_PACKET_TYPE:    type_field    = cfg_wdata;
                    CFG_FORMAT_VERSION: version_field = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                frame_transaction(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[47:40]);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                compare_output();
            pending_bytes <= framed_bytes_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_crc_packet_framer.sv
`timescale 1ns / 100ps

module tb_crc_packet_framer;
    import cpf_pkg::*;

    localparam int ITEM_TARGET  = 410;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;

    // Indexes past the register file, expected to be ignored
    localparam logic [1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [1:0] CFG_UNUSED_HI = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata = 48'd0;   // timestamp[31:0], frame_count[39:32], data_byte[47:40]
    logic        s_tuser = 1'b0;    // kind
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;           // out_byte[7:0]
    wire         m_tlast;
    wire         m_tuser;           // rejected

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int items_sent = 0;
    int cycle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    crc_packet_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    crc_packet_framer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output backpressure: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request <= 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One input transaction, with random idle cycles in front of it
    task automatic send_item(input logic kind, input logic [31:0] ts,
                             input logic [7:0] fc, input logic [7:0] db);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {db, fc, ts};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
    endtask

    // Start with junk in the payload byte
    task automatic send_start(input logic [31:0] ts, input logic [7:0] fc);
        send_item(KIND_START, ts, fc, 8'($urandom_range(255)));
        items_sent++;
    endtask

    // Payload with junk in the start fields
    task automatic send_payload(input logic [7:0] db);
        send_item(KIND_PAYLOAD, $urandom, 8'($urandom_range(255)), db);
        items_sent++;
    endtask

    task automatic send_packet(input int fc, input int n_payload);
        send_start($urandom, 8'(fc));
        repeat (n_payload)
            send_payload(8'($urandom_range(255)));
    endtask

    // Mostly small packets, now and then a large one
    function automatic int pick_frames();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 1;
        else if (r < 80)
            return 2;
        else
            return $urandom_range(MAX_FRAMES, 3);
    endfunction

    // Shrink a packet toward the items left in this phase, but not below one frame
    function automatic int fit_frames(input int fc, input int budget);
        int f;
        f = fc;
        while (f > 1 && f * FRAME_BYTES + 1 > budget)
            f--;
        return f;
    endfunction

    task automatic random_burst(input int budget);
        int pick;
        int fc;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            fc = fit_frames(pick_frames(), budget);
            send_packet(fc, fc * FRAME_BYTES);
        end
        else if (pick < 80)
        begin
            // cut short, the next start abandons it
            fc = fit_frames(pick_frames(), budget);
            send_packet(fc, $urandom_range(fc * FRAME_BYTES - 1));
        end
        else if (pick < 90)
        begin
            if ($urandom_range(1) == 0)
                send_start($urandom, 8'd0);
            else
                send_start($urandom, 8'($urandom_range(255, MAX_FRAMES + 1)));
        end
        else
        begin
            // stray payload, dropped unless a packet is still open
            repeat ($urandom_range(3, 1))
                send_payload(8'($urandom_range(255)));
        end
    endtask

    // Stop sending and let every expected byte come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_header_fields(input logic [7:0] pt, input logic [7:0] fv);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PACKET_TYPE;
        cfg_wdata <= pt;
        @(posedge clk);
        cfg_index <= CFG_FORMAT_VERSION;
        cfg_wdata <= fv;
        @(posedge clk);
        cfg_index <= CFG_UNUSED_LO;
        cfg_wdata <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_index <= CFG_UNUSED_HI;
        cfg_wdata <= 8'($urandom_range(255));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, header fields at reset values
        send_item(KIND_PAYLOAD, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_start(32'h0000_0000, 8'd0);
        send_start(32'h1234_5678, 8'(MAX_FRAMES + 1));
        send_start(32'hFFFF_FFFF, 8'hFF);
        send_start(32'h0000_0000, 8'(MAX_FRAMES));
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        send_start(32'hFFFF_FFFF, 8'd1);
        send_payload(8'h80);
        send_start(32'h8000_0001, 8'd0);
        send_item(KIND_PAYLOAD, 32'h0, 8'd1, 8'h01);
        send_packet(1, FRAME_BYTES);
        wait_idle();

        // Random part in four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_header_fields(8'h00, 8'h00);
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                    hold_request   <= HOLD_CYCLES;
                end
                1:
                begin
                    write_header_fields(8'hFF, 8'hFF);
                    send_idle_pct   = 54;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    write_header_fields(8'($urandom_range(255)), 8'($urandom_range(255)));
                    send_idle_pct   = 0;
                    recv_stall_pct <= 54;
                end
                default:
                begin
                    write_header_fields(8'($urandom_range(255)), 8'($urandom_range(255)));
                    send_idle_pct   = 15;
                    recv_stall_pct <= 15;
                end
            endcase
            while (items_sent < ITEM_TARGET * (phase + 1) / 4)
                random_burst(ITEM_TARGET * (phase + 1) / 4 - items_sent);
            wait_idle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cpf_pkg.sv
rtl/cpf_front.sv
rtl/cpf_fifo.sv
rtl/cpf_back.sv
rtl/crc_packet_framer.sv
tb/sv/crc_packet_framer_checker.sv
tb/sv/tb_crc_packet_framer.sv
